>>> src/dedup_keep_last_by_key_defines.svh
// assertion macros for the checker
`ifndef DEDUP_KEEP_LAST_BY_KEY_DEFINES_SVH
`define DEDUP_KEEP_LAST_BY_KEY_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DKL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dedup check failed");

// next-cycle implication, sampled on clock, off during reset
`define DKL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dedup check failed");

`endif

>>> src/dkl_pkg.sv
package dkl_pkg;

   // default sizing
   localparam int COORD_BITS_DEF  = 4;
   localparam int MAX_ENTRIES_DEF = 1024;

   // fixed field widths of the request and response words
   localparam int COORD_W  = 4;
   localparam int KIND_W   = 2;
   localparam int KEPT_W   = 10;
   localparam int BEFORE_W = 11;
   localparam int DUPS_W   = 10;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_FETCH = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RDA,
      ST_ADD_RDB,
      ST_ADD_WR,
      ST_FETCH_ADDR,
      ST_FETCH_DATA
   } state_type;

   // request word
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] local_x;
      logic [COORD_W-1:0] local_y;
      logic [COORD_W-1:0] local_z;
   } req_type;

   // response word
   typedef struct packed {
      logic                found;
      logic [KEPT_W-1:0]   kept_position;
      logic [BEFORE_W-1:0] entries_before;
      logic [BEFORE_W-1:0] entries_after;
      logic [DUPS_W-1:0]   dup_total;
      logic                overflowed;
   } rsp_type;

   // memory strobes from the controller
   typedef struct packed {
      logic key_rd;
      logic key_wr;
      logic pos_rd;
      logic pos_wr;
   } mem_ctl_type;

endpackage

>>> src/dkl_key_table.sv
module dkl_key_table #(
   parameter int KEY_W = 12,
   parameter int POS_W = 10
) (
   input  logic                  clock,
   input  dkl_pkg::mem_ctl_type  ctl,
   input  logic [KEY_W-1:0]      addr,
   input  logic [POS_W-1:0]      wdata,
   output logic [POS_W-1:0]      rdata
);
   import dkl_pkg::*;

   localparam int DEPTH = 1 << KEY_W;

   logic [POS_W-1:0] mem [DEPTH];
   logic [POS_W-1:0] rdata_ff;

   // key to latest position, registered read
   always_ff @(posedge clock) begin
      if (ctl.key_wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.key_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/dkl_pos_table.sv
module dkl_pos_table #(
   parameter int MAX_ENTRIES = 1024,
   parameter int POS_W       = 10,
   parameter int ENTRY_W     = 13
) (
   input  logic                  clock,
   input  dkl_pkg::mem_ctl_type  ctl,
   input  logic [POS_W-1:0]      addr,
   input  logic [ENTRY_W-1:0]    wdata,
   output logic [ENTRY_W-1:0]    rdata
);
   import dkl_pkg::*;

   logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] rdata_ff;

   // position to {kept, key}, registered read
   always_ff @(posedge clock) begin
      if (ctl.pos_wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.pos_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/dkl_ctrl.sv
module dkl_ctrl #(
   parameter int COORD_BITS  = 4,
   parameter int MAX_ENTRIES = 1024,
   parameter int KEY_W       = 3 * COORD_BITS,
   parameter int POS_W       = $clog2(MAX_ENTRIES),
   parameter int ENTRY_W     = KEY_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dkl_pkg::req_type      req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output dkl_pkg::rsp_type      rsp_data,
   output dkl_pkg::mem_ctl_type  ctl,
   output logic [KEY_W-1:0]      key_addr,
   output logic [POS_W-1:0]      key_wdata,
   input  logic [POS_W-1:0]      key_rdata,
   output logic [POS_W-1:0]      pos_addr,
   output logic [ENTRY_W-1:0]    pos_wdata,
   input  logic [ENTRY_W-1:0]    pos_rdata
);
   import dkl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  dup_ff, dup_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [KEY_W-1:0]  req_key;
   logic              is_dup;
   logic [CNT_W-1:0]  after_cnt;

   // key packs x:y:z, coordinate bits above COORD_BITS dropped
   assign req_key = {COORD_BITS'(req_data.local_x), COORD_BITS'(req_data.local_y),
                     COORD_BITS'(req_data.local_z)};

   // stored position is live only if it is in this batch and points back at the key
   assign is_dup = (CNT_W'(key_rdata) < count_ff) && (pos_rdata[KEY_W-1:0] == key_ff);

   assign after_cnt = count_ff - dup_ff;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dup_ff       <= '0;
         scan_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dup_ff       <= dup_in;
         scan_ff      <= scan_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   // sequencer: next state, memory strobes and response word
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      dup_in       = dup_ff;
      scan_in      = scan_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      key_addr     = key_ff;
      key_wdata    = count_ff[POS_W-1:0];
      pos_addr     = key_rdata;
      pos_wdata    = '0;

      // counters go with every response
      rsp_in.entries_before = BEFORE_W'(count_ff);
      rsp_in.entries_after  = BEFORE_W'(after_cnt);
      rsp_in.dup_total      = DUPS_W'(dup_ff);
      rsp_in.overflowed     = ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            key_addr = req_key;
            if (start) begin
               case (req_data.kind)
                  KIND_ADD: begin
                     if (count_ff == MAX_CNT) begin
                        ovf_in = 1'b1;
                     end else begin
                        ctl.key_rd = 1'b1;
                        key_in     = req_key;
                        state_in   = ST_ADD_RDA;
                     end
                  end
                  KIND_FETCH: begin
                     state_in = ST_FETCH_ADDR;
                  end
                  KIND_START: begin
                     count_in = '0;
                     dup_in   = '0;
                     scan_in  = '0;
                     ovf_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // previous position of the key is back, look it up
         ST_ADD_RDA: begin
            ctl.pos_rd = 1'b1;
            pos_addr   = key_rdata;
            state_in   = ST_ADD_RDB;
         end

         // unmark the superseded position and point the key at the new one
         ST_ADD_RDB: begin
            pos_addr   = key_rdata;
            ctl.key_wr = 1'b1;
            if (is_dup) begin
               ctl.pos_wr = 1'b1;
               pos_wdata  = {1'b0, pos_rdata[KEY_W-1:0]};
               dup_in     = dup_ff + 1'b1;
            end
            state_in = ST_ADD_WR;
         end

         // mark the new position kept
         ST_ADD_WR: begin
            pos_addr   = count_ff[POS_W-1:0];
            ctl.pos_wr = 1'b1;
            pos_wdata  = {1'b1, key_ff};
            count_in   = count_ff + 1'b1;
            state_in   = ST_IDLE;
         end

         // scan: stop at end of batch or read the next kept bit
         ST_FETCH_ADDR: begin
            pos_addr = scan_ff[POS_W-1:0];
            if (scan_ff >= count_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = 1'b0;
               rsp_in.kept_position = '0;
               state_in             = ST_IDLE;
            end else begin
               ctl.pos_rd = 1'b1;
               state_in   = ST_FETCH_DATA;
            end
         end

         ST_FETCH_DATA: begin
            scan_in = scan_ff + 1'b1;
            if (pos_rdata[KEY_W]) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = 1'b1;
               rsp_in.kept_position = KEPT_W'(scan_ff);
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_FETCH_ADDR;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/dedup_keep_last_by_key.sv
// Keep-last deduplication by key. A word is taken when start is high and busy is low.
// Add words number entries in arrival order and remember, per x:y:z key, the latest one;
// a repeated key unmarks the older entry and counts a duplicate. Fetch words return the
// surviving positions in ascending order, one per fetch, with the batch counters; a start
// word opens a new batch with no memory clearing pass, since a key table entry counts only
// if it lies inside the batch and the position table points back at it.
// Start batch words, unused kinds and adds to a full batch never raise busy; an add holds
// busy while it reads the position table, writes the key table, unmarks any superseded
// entry and then marks the new position kept; a fetch holds busy while it checks the end
// of the batch and reads each examined position in turn through the single position
// table read port. rsp_valid is high for exactly one cycle, the first one with busy low
// again, and qualifies rsp_data; the receiver cannot stall it, so it must capture every
// strobe. Only fetch words produce a response.
module dedup_keep_last_by_key #(
   parameter int COORD_BITS  = dkl_pkg::COORD_BITS_DEF,
   parameter int MAX_ENTRIES = dkl_pkg::MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dkl_pkg::req_type  req_data,
   output logic              busy,
   output logic              rsp_valid,
   output dkl_pkg::rsp_type  rsp_data
);
   import dkl_pkg::*;

   localparam int KEY_W   = 3 * COORD_BITS;
   localparam int POS_W   = $clog2(MAX_ENTRIES);
   localparam int ENTRY_W = KEY_W + 1;

   mem_ctl_type         ctl;
   logic [KEY_W-1:0]    key_addr;
   logic [POS_W-1:0]    key_wdata;
   logic [POS_W-1:0]    key_rdata;
   logic [POS_W-1:0]    pos_addr;
   logic [ENTRY_W-1:0]  pos_wdata;
   logic [ENTRY_W-1:0]  pos_rdata;

   // sequencer
   dkl_ctrl #(
      .COORD_BITS  (COORD_BITS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_W       (KEY_W),
      .POS_W       (POS_W),
      .ENTRY_W     (ENTRY_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .key_addr  (key_addr),
      .key_wdata (key_wdata),
      .key_rdata (key_rdata),
      .pos_addr  (pos_addr),
      .pos_wdata (pos_wdata),
      .pos_rdata (pos_rdata)
   );

   // key to latest position
   dkl_key_table #(
      .KEY_W (KEY_W),
      .POS_W (POS_W)
   ) u_key_table (
      .clock (clock),
      .ctl   (ctl),
      .addr  (key_addr),
      .wdata (key_wdata),
      .rdata (key_rdata)
   );

   // position to kept bit and key
   dkl_pos_table #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .POS_W       (POS_W),
      .ENTRY_W     (ENTRY_W)
   ) u_pos_table (
      .clock (clock),
      .ctl   (ctl),
      .addr  (pos_addr),
      .wdata (pos_wdata),
      .rdata (pos_rdata)
   );

endmodule

>>> src/dkl_checker.sv
`include "dedup_keep_last_by_key_defines.svh"

module dkl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input dkl_pkg::req_type  req_data,
   input logic              busy,
   input logic              rsp_valid,
   input dkl_pkg::rsp_type  rsp_data
);
   import dkl_pkg::*;

   logic [BEFORE_W-1:0] sum_cnt;

   // after plus duplicates rebuilds before
   assign sum_cnt = rsp_data.entries_after + BEFORE_W'(rsp_data.dup_total);

   // a response always ends a busy stretch
   `DKL_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy))

   // a taken fetch word occupies the block
   `DKL_ASSERT_NEXT(a_fetch_busy, start && !busy && (req_data.kind == KIND_FETCH), busy)

   // an empty fetch reports position zero
   `DKL_ASSERT_SAME(a_empty_zero, rsp_valid && !rsp_data.found, rsp_data.kept_position == '0)

   // counters are consistent: after plus duplicates equals before
   `DKL_ASSERT_SAME(a_count_sum, rsp_valid, sum_cnt == rsp_data.entries_before)

endmodule

bind dedup_keep_last_by_key dkl_checker u_dkl_checker (.*);
